// ----- rtl/core/nearest_upsample_4d_defines.svh -----
// assertion macros for the nearest upsample block
// used by files that include it with a clk_i / rst_ni pair in scope
`ifndef NEAREST_UPSAMPLE_4D_DEFINES_SVH
`define NEAREST_UPSAMPLE_4D_DEFINES_SVH

`ifndef ASSERT_OFF
`define NU4D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nu4d assertion failed");
`define NU4D_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("nu4d reset assertion failed");
`else
`define NU4D_ASSERT(lbl, prop)
`define NU4D_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- rtl/core/nu4d_pkg.sv -----
// package for the nearest upsample block: item types, register codes, defaults
// no dependencies
package nu4d_pkg;

  localparam int unsigned DefStoreDepth = 65536;
  localparam int unsigned DefElementBits = 64;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned ScaleBits = 24;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdBits = CoordBits + ScaleBits;
  localparam int unsigned CfgIndexBits = 4;

  localparam logic [CoordBits-1:0] SizeReset = 16'd1;
  localparam logic [ScaleBits-1:0] InvScaleReset = 24'd65536;

  typedef enum logic [0:0] {
    CmdLoad  = 1'b0,
    CmdFetch = 1'b1
  } cmd_e;

  typedef enum logic [CfgIndexBits-1:0] {
    RegSizeBatch       = 4'd0,
    RegSizeChannel     = 4'd1,
    RegSizeHeight      = 4'd2,
    RegSizeWidth       = 4'd3,
    RegInvScaleBatch   = 4'd4,
    RegInvScaleChannel = 4'd5,
    RegInvScaleHeight  = 4'd6,
    RegInvScaleWidth   = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    cmd_e        command;
    logic [15:0] load_address;
    logic [63:0] load_value;
    logic [15:0] out_batch;
    logic [15:0] out_channel;
    logic [15:0] out_row;
    logic [15:0] out_column;
  } in_item_t;

  typedef struct packed {
    logic [63:0] element_value;
    logic [15:0] source_address;
  } out_item_t;

  // a zero size behaves as size one
  function automatic logic [CoordBits-1:0] extent(input logic [CoordBits-1:0] size);
    extent = (size == '0) ? CoordBits'(1) : size;
  endfunction

endpackage

// ----- rtl/core/nearest_upsample_4d.sv -----
// Nearest-neighbor 4D upsampler: a source tensor in a single-port store, loaded and
// fetched through one item channel. A fetch's result is registered from the store read,
// and the pipeline takes one item per cycle as long as no result waits under a stall;
// a stalled result freezes every stage. Each item touches the store once, in one fixed
// stage, so loads and fetches take effect strictly in arrival order. Source coordinates
// take one 16x24 multiply per axis, the flat address three chained multiplies, one per
// stage. The store is not cleared: fetch only addresses that were loaded. STORE_DEPTH
// must be a power of two; addresses wrap at that depth.
// depends on nu4d_pkg and nearest_upsample_4d_defines.svh
`include "nearest_upsample_4d_defines.svh"

module nearest_upsample_4d #(
  parameter int unsigned STORE_DEPTH  = nu4d_pkg::DefStoreDepth,
  parameter int unsigned ELEMENT_BITS = nu4d_pkg::DefElementBits
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  nu4d_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output nu4d_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nu4d_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [nu4d_pkg::ScaleBits-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned EW = ELEMENT_BITS;
  localparam int unsigned CB = nu4d_pkg::CoordBits;
  localparam int unsigned SB = nu4d_pkg::ScaleBits;
  localparam int unsigned PB = nu4d_pkg::ProdBits;
  localparam int unsigned FB = nu4d_pkg::FracBits;

  // configuration
  logic [CB-1:0] size_q [4];
  logic [SB-1:0] inv_q  [4];
  logic [CB-1:0] ext    [4];
  logic [CB-1:0] top    [4];

  // pipeline
  logic             adv;
  logic             vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, out_vld_q;
  logic             out_vld_d;
  nu4d_pkg::cmd_e   cmd1_q, cmd2_q, cmd3_q, cmd4_q, cmd5_q, cmd6_q;
  logic [AW-1:0]    la1_d, la1_q, la2_q, la3_q, la4_q, la5_q;
  logic [EW-1:0]    lv1_q, lv2_q, lv3_q, lv4_q, lv5_q, lv6_q;
  logic [CB-1:0]    co1_q   [4];
  logic [PB-1:0]    prod2_d [4];
  logic [PB-1:0]    prod2_q [4];
  logic [CB-1:0]    src3_d  [4];
  logic [CB-1:0]    src3_q  [4];
  logic [CB-1:0]    srch4_q, srcw4_q, srcw5_q;
  logic [AW-1:0]    t4_d, t4_q, t5_d, t5_q, addr6_d, addr6_q, out_addr_q;
  logic [AW+CB-1:0] la_wide, m4, m5, m6, sc_wide, sh_wide, sw_wide;
  logic [AW+15:0]   oa_wide;
  logic [EW+63:0]   ev_wide;

  // source store
  logic [EW-1:0]    store_q [STORE_DEPTH];
  logic [EW-1:0]    rdata_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        size_q[i] <= nu4d_pkg::SizeReset;
        inv_q[i]  <= nu4d_pkg::InvScaleReset;
      end
    end else if (cfg_valid_i) begin
      case (nu4d_pkg::cfg_reg_e'(cfg_index_i))
        nu4d_pkg::RegSizeBatch:       size_q[0] <= cfg_data_i[CB-1:0];
        nu4d_pkg::RegSizeChannel:     size_q[1] <= cfg_data_i[CB-1:0];
        nu4d_pkg::RegSizeHeight:      size_q[2] <= cfg_data_i[CB-1:0];
        nu4d_pkg::RegSizeWidth:       size_q[3] <= cfg_data_i[CB-1:0];
        nu4d_pkg::RegInvScaleBatch:   inv_q[0]  <= cfg_data_i;
        nu4d_pkg::RegInvScaleChannel: inv_q[1]  <= cfg_data_i;
        nu4d_pkg::RegInvScaleHeight:  inv_q[2]  <= cfg_data_i;
        nu4d_pkg::RegInvScaleWidth:   inv_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ext[i] = nu4d_pkg::extent(size_q[i]);
      top[i] = ext[i] - CB'(1);
    end
  end

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // per-stage datapath
  always_comb begin
    la_wide = {{AW{1'b0}}, in_item_i.load_address};
    la1_d   = la_wide[AW-1:0];
    for (int i = 0; i < 4; i++) begin
      prod2_d[i] = {{SB{1'b0}}, co1_q[i]} * {{CB{1'b0}}, inv_q[i]};
      src3_d[i]  = (prod2_q[i][PB-1:FB] > {{(SB-CB){1'b0}}, top[i]}) ? top[i]
                                                                      : prod2_q[i][FB+CB-1:FB];
    end
    sc_wide = {{AW{1'b0}}, src3_q[1]};
    m4      = {{AW{1'b0}}, src3_q[0]} * {{AW{1'b0}}, ext[1]};
    t4_d    = m4[AW-1:0] + sc_wide[AW-1:0];
    sh_wide = {{AW{1'b0}}, srch4_q};
    m5      = {{CB{1'b0}}, t4_q} * {{AW{1'b0}}, ext[2]};
    t5_d    = m5[AW-1:0] + sh_wide[AW-1:0];
    sw_wide = {{AW{1'b0}}, srcw5_q};
    m6      = {{CB{1'b0}}, t5_q} * {{AW{1'b0}}, ext[3]};
    addr6_d = (cmd5_q == nu4d_pkg::CmdLoad) ? la5_q : (m6[AW-1:0] + sw_wide[AW-1:0]);
    out_vld_d = vld6_q && (cmd6_q == nu4d_pkg::CmdFetch);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      vld6_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld1_q    <= in_valid_i;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      vld5_q    <= vld4_q;
      vld6_q    <= vld5_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q    <= in_item_i.command;
      la1_q     <= la1_d;
      lv1_q     <= in_item_i.load_value[EW-1:0];
      co1_q[0]  <= in_item_i.out_batch;
      co1_q[1]  <= in_item_i.out_channel;
      co1_q[2]  <= in_item_i.out_row;
      co1_q[3]  <= in_item_i.out_column;
      cmd2_q    <= cmd1_q;
      la2_q     <= la1_q;
      lv2_q     <= lv1_q;
      prod2_q   <= prod2_d;
      cmd3_q    <= cmd2_q;
      la3_q     <= la2_q;
      lv3_q     <= lv2_q;
      src3_q    <= src3_d;
      cmd4_q    <= cmd3_q;
      la4_q     <= la3_q;
      lv4_q     <= lv3_q;
      t4_q      <= t4_d;
      srch4_q   <= src3_q[2];
      srcw4_q   <= src3_q[3];
      cmd5_q    <= cmd4_q;
      la5_q     <= la4_q;
      lv5_q     <= lv4_q;
      t5_q      <= t5_d;
      srcw5_q   <= srcw4_q;
      cmd6_q    <= cmd5_q;
      lv6_q     <= lv5_q;
      addr6_q   <= addr6_d;
      out_addr_q <= addr6_q;
    end
  end

  // store access, one per item, in arrival order
  always_ff @(posedge clk_i) begin
    if (adv && vld6_q && (cmd6_q == nu4d_pkg::CmdLoad)) begin
      store_q[addr6_q] <= lv6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld6_q && (cmd6_q == nu4d_pkg::CmdFetch)) begin
      rdata_q <= store_q[addr6_q];
    end
  end

  always_comb begin
    ev_wide                   = {64'b0, rdata_q};
    oa_wide                   = {16'b0, out_addr_q};
    out_item_o.element_value  = ev_wide[63:0];
    out_item_o.source_address = oa_wide[15:0];
  end

  assign out_valid_o = out_vld_q;

  `NU4D_ASSERT(fetch_gives_result_a,
    (adv && vld6_q && (cmd6_q == nu4d_pkg::CmdFetch)) |=> out_valid_o)
  `NU4D_ASSERT(load_gives_none_a,
    (adv && vld6_q && (cmd6_q == nu4d_pkg::CmdLoad)) |=> !out_valid_o)
  `NU4D_ASSERT(src_clamped_a,
    vld3_q |-> ((src3_q[2] <= top[2]) && (src3_q[3] <= top[3])))
  `NU4D_ASSERT(stall_freezes_a,
    !adv |=> $stable({vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q}))

endmodule
